// File: rtl/core/multi_joint_pid_torque_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the multi-joint PID torque controller
// Shared property shapes, sampled on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef MULTI_JOINT_PID_TORQUE_DEFINES_SVH
`define MULTI_JOINT_PID_TORQUE_DEFINES_SVH

// The consequent must hold on the same edge as the antecedent.
`define MJPT_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold on the edge after the antecedent.
`define MJPT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/mjpt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mjpt_pkg
// Widths, register codes, reset values and shared types of the multi-joint
// PID torque controller.
// ----------------------------------------------------------------------------
package mjpt_pkg;

	// Joint store depth and index width.
	localparam int unsigned JOINTS_DEFAULT = 8;
	localparam int unsigned JOINT_W        = 3;
	localparam int unsigned JOINT_CODES    = 2 ** JOINT_W;

	// Stream and configuration port widths.
	localparam int unsigned FIELD_W     = 16;
	localparam int unsigned S_TDATA_W   = 6 * FIELD_W;
	localparam int unsigned S_TUSER_W   = JOINT_W;
	localparam int unsigned M_TDATA_W   = 16;
	localparam int unsigned M_TUSER_W   = JOINT_W + 1;
	localparam int unsigned CLAMP_BIT   = JOINT_W;
	localparam int unsigned CFG_INDEX_W = 1;
	localparam int unsigned CFG_DATA_W  = 16;

	// Register indices.
	localparam logic [CFG_INDEX_W-1:0] REG_STEP_TIME    = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_TORQUE_LIMIT = 1'b1;

	// Register widths and reset values.
	localparam int unsigned STEP_TIME_W = 16;
	localparam int unsigned LIMIT_W     = 15;
	localparam logic [STEP_TIME_W-1:0] STEP_TIME_RESET    = 16'd655;
	localparam logic [LIMIT_W-1:0]     TORQUE_LIMIT_RESET = 15'd12800;

	// Arithmetic widths.
	localparam int unsigned ERR_W        = FIELD_W + 1;
	localparam int unsigned INTEG_W      = 32;
	localparam int unsigned MPLIER_W     = 16;
	localparam int unsigned DIGIT_W      = 8;
	localparam int unsigned DIGITS       = MPLIER_W / DIGIT_W;
	localparam int unsigned DIGIT_CNT_W  = $clog2(DIGITS + 1);
	localparam int unsigned ACC_W        = 49;
	localparam int unsigned INC_SHIFT    = 12;
	localparam int unsigned INC_W        = ERR_W + MPLIER_W - INC_SHIFT;
	localparam int unsigned GAIN_SHIFT   = 4;
	localparam int unsigned TORQUE_SHIFT = 16;
	localparam int unsigned TQ_W         = ACC_W - TORQUE_SHIFT;

	// Saturation bounds of the integral.
	localparam logic signed [INTEG_W-1:0] INTEG_MAX = {1'b0, {(INTEG_W-1){1'b1}}};
	localparam logic signed [INTEG_W-1:0] INTEG_MIN = {1'b1, {(INTEG_W-1){1'b0}}};

	// Commands to the serial multiply-accumulate unit.
	typedef struct packed {
		logic start;
		logic clear;
	} mjpt_mac_ctrl_t;

	// Address width of a store of n joints.
	function automatic int unsigned slot_w(int unsigned n);
		return (n > 1) ? $clog2(n) : 1;
	endfunction

endpackage

// File: rtl/core/mjpt_serial_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mjpt_serial_mac
// Digit-serial multiply-accumulate: a signed multiplicand times an unsigned
// multiplier taken one digit per cycle, least significant digit first.
// ----------------------------------------------------------------------------
module mjpt_serial_mac (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  mjpt_pkg::mjpt_mac_ctrl_t             ctrl,
	input  logic signed [mjpt_pkg::ACC_W-1:0]    mcand,
	input  logic        [mjpt_pkg::MPLIER_W-1:0] mplier,
	output logic                                 busy,
	output logic signed [mjpt_pkg::ACC_W-1:0]    acc
);
	import mjpt_pkg::*;

	localparam int unsigned PROD_W = ACC_W + DIGIT_W + 1;

	logic        [DIGIT_CNT_W-1:0] cnt_q;
	logic signed [ACC_W-1:0]       mcand_q;
	logic signed [ACC_W-1:0]       acc_q;
	logic        [MPLIER_W-1:0]    mplier_q;
	logic signed [DIGIT_W:0]       digit_s;
	logic signed [PROD_W-1:0]      prod;

	// Partial product of the current digit.
	assign digit_s = {1'b0, mplier_q[DIGIT_W-1:0]};
	assign prod    = mcand_q * digit_s;

	assign busy = (cnt_q != '0);
	assign acc  = acc_q;

	// Digit counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctrl.start) begin
			cnt_q <= DIGIT_CNT_W'(DIGITS);
		end else if (busy) begin
			cnt_q <= cnt_q - DIGIT_CNT_W'(1);
		end
	end

	// Operand shift registers and accumulator.
	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			mcand_q  <= mcand;
			mplier_q <= mplier;
			if (ctrl.clear) begin
				acc_q <= '0;
			end
		end else if (busy) begin
			acc_q    <= acc_q + $signed(prod[ACC_W-1:0]);
			mcand_q  <= mcand_q <<< DIGIT_W;
			mplier_q <= mplier_q >> DIGIT_W;
		end
	end

endmodule

// File: rtl/core/mjpt_integ_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mjpt_integ_store
// Per-joint integral memory with a registered read port and one valid bit
// per entry, so that an entry never written since reset reads as zero.
// ----------------------------------------------------------------------------
module mjpt_integ_store #(
	parameter int unsigned JOINTS = mjpt_pkg::JOINTS_DEFAULT
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          rd_en,
	input  logic        [mjpt_pkg::slot_w(JOINTS)-1:0]    rd_addr,
	output logic signed [mjpt_pkg::INTEG_W-1:0]           rd_data,
	input  logic                                          wr_en,
	input  logic        [mjpt_pkg::slot_w(JOINTS)-1:0]    wr_addr,
	input  logic signed [mjpt_pkg::INTEG_W-1:0]           wr_data
);
	import mjpt_pkg::*;

	logic signed [INTEG_W-1:0] mem [JOINTS];
	logic        [JOINTS-1:0]  valid_q;
	logic signed [INTEG_W-1:0] rd_data_q;

	assign rd_data = rd_data_q;

	// Memory write and registered read.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= valid_q[rd_addr] ? mem[rd_addr] : '0;
		end
	end

	// Entries become valid once written.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

endmodule

// File: rtl/core/multi_joint_pid_torque.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_joint_pid_torque
// Per-joint PID torque controller in fixed point, built around one shared
// digit-serial multiply-accumulate unit.
//
//   channel   signals                          word
//   s_axis    tvalid tready tdata[95:0] tuser  one joint sample with gains
//   m_axis    tvalid tready tdata[15:0] tuser  clamped torque, joint, flag
//   cfg       valid ready index data           one register write
//
// Each item runs four products on the shared unit, each of two 8-bit
// multiplier digits and each launched by the sequencer before its digits,
// then loads the output register; the next word is accepted after that.
// Reset clears the integral store at once through per-entry valid bits.
// A stalled output holds the finished item in the last state; the next
// word can be taken while an earlier result waits in the output register.
// ----------------------------------------------------------------------------
module multi_joint_pid_torque #(
	parameter int unsigned JOINTS = mjpt_pkg::JOINTS_DEFAULT
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// target, position, velocity, kp_gain, ki_gain, kd_gain (lowest first)
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [mjpt_pkg::S_TDATA_W-1:0]      s_axis_tdata,
	// joint
	input  logic [mjpt_pkg::S_TUSER_W-1:0]      s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// torque
	output logic [mjpt_pkg::M_TDATA_W-1:0]      m_axis_tdata,
	// joint_out, clamped (lowest first)
	output logic [mjpt_pkg::M_TUSER_W-1:0]      m_axis_tuser,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [mjpt_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [mjpt_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import mjpt_pkg::*;

	localparam int unsigned SLOT_W = slot_w(JOINTS);

	// Sequencer states.
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_INTEG = 3'd1;
	localparam logic [2:0] ST_PROP  = 3'd2;
	localparam logic [2:0] ST_DERIV = 3'd3;
	localparam logic [2:0] ST_ITERM = 3'd4;

	logic [2:0]                state_q;
	logic [2:0]                state_d;
	logic [STEP_TIME_W-1:0]    step_time_q;
	logic [LIMIT_W-1:0]        torque_limit_q;

	logic [JOINT_W-1:0]        joint_q;
	logic [SLOT_W-1:0]         slot_q;
	logic signed [ERR_W-1:0]   err_q;
	logic signed [ERR_W-1:0]   nvel_q;
	logic [FIELD_W-1:0]        kp_q;
	logic [FIELD_W-1:0]        ki_q;
	logic [FIELD_W-1:0]        kd_q;
	logic signed [INTEG_W-1:0] integ_q;

	logic                      m_valid_q;
	logic [M_TDATA_W-1:0]      m_torque_q;
	logic [JOINT_W-1:0]        m_joint_q;
	logic                      m_clamped_q;

	logic signed [FIELD_W-1:0] in_target;
	logic signed [FIELD_W-1:0] in_position;
	logic signed [FIELD_W-1:0] in_velocity;
	logic signed [ERR_W-1:0]   in_err;
	logic signed [ERR_W-1:0]   in_nvel;
	logic                      s_accept;
	logic                      out_free;
	logic                      out_load;
	logic                      integ_wr;

	logic [SLOT_W-1:0]         slot_lut [JOINT_CODES];

	mjpt_mac_ctrl_t            mac_ctrl;
	logic signed [ACC_W-1:0]   mac_mcand;
	logic [MPLIER_W-1:0]       mac_mplier;
	logic                      mac_busy;
	logic signed [ACC_W-1:0]   mac_acc;

	logic signed [INTEG_W-1:0] old_integ;
	logic signed [INC_W-1:0]   integ_inc;
	logic signed [INTEG_W+1:0] integ_sum;
	logic signed [INTEG_W-1:0] integ_new;

	logic signed [TQ_W-1:0]    tq_raw;
	logic signed [TQ_W-1:0]    lim_pos;
	logic signed [TQ_W-1:0]    lim_neg;
	logic [M_TDATA_W-1:0]      tq_out;
	logic                      tq_clip;

	// Input word fields.
	assign in_target   = s_axis_tdata[0*FIELD_W +: FIELD_W];
	assign in_position = s_axis_tdata[1*FIELD_W +: FIELD_W];
	assign in_velocity = s_axis_tdata[2*FIELD_W +: FIELD_W];
	assign in_err      = {in_target[FIELD_W-1], in_target}
		- {in_position[FIELD_W-1], in_position};
	assign in_nvel     = -{in_velocity[FIELD_W-1], in_velocity};

	// Joint code to store slot, folded modulo the store depth.
	for (genvar g = 0; g < JOINT_CODES; g++) begin : g_slot
		assign slot_lut[g] = SLOT_W'(g % JOINTS);
	end

	// Handshakes.
	assign s_axis_tready = (state_q == ST_IDLE);
	assign s_accept      = s_axis_tvalid && s_axis_tready;
	assign out_free      = !m_valid_q || m_axis_tready;
	assign cfg_ready     = 1'b1;

	// Integral update: add (error * dt) >> 12 and saturate to 32 bits.
	assign integ_inc = mac_acc[ERR_W+MPLIER_W-1:INC_SHIFT];
	assign integ_sum = {{2{old_integ[INTEG_W-1]}}, old_integ}
		+ {{(INTEG_W+2-INC_W){integ_inc[INC_W-1]}}, integ_inc};

	always_comb begin
		if ((integ_sum[INTEG_W+1:INTEG_W-1] == '0) || (integ_sum[INTEG_W+1:INTEG_W-1] == '1)) begin
			integ_new = integ_sum[INTEG_W-1:0];
		end else if (integ_sum[INTEG_W+1]) begin
			integ_new = INTEG_MIN;
		end else begin
			integ_new = INTEG_MAX;
		end
	end

	// Torque: Q.24 sum floored to Q8.8, then clamped to the limit.
	assign tq_raw  = mac_acc[ACC_W-1:TORQUE_SHIFT];
	assign lim_pos = {{(TQ_W-LIMIT_W){1'b0}}, torque_limit_q};
	assign lim_neg = -lim_pos;

	always_comb begin
		if (tq_raw > lim_pos) begin
			tq_out  = lim_pos[M_TDATA_W-1:0];
			tq_clip = 1'b1;
		end else if (tq_raw < lim_neg) begin
			tq_out  = lim_neg[M_TDATA_W-1:0];
			tq_clip = 1'b1;
		end else begin
			tq_out  = tq_raw[M_TDATA_W-1:0];
			tq_clip = 1'b0;
		end
	end

	// Sequencer: launches each product on the shared unit in turn.
	always_comb begin
		state_d    = state_q;
		mac_ctrl   = '0;
		mac_mcand  = '0;
		mac_mplier = '0;
		integ_wr   = 1'b0;
		out_load   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (s_accept) begin
					mac_ctrl.start = 1'b1;
					mac_ctrl.clear = 1'b1;
					mac_mcand  = {{(ACC_W-ERR_W){in_err[ERR_W-1]}}, in_err};
					mac_mplier = step_time_q;
					state_d    = ST_INTEG;
				end
			end
			ST_INTEG: begin
				if (!mac_busy) begin
					integ_wr       = 1'b1;
					mac_ctrl.start = 1'b1;
					mac_ctrl.clear = 1'b1;
					mac_mcand  = {{(ACC_W-ERR_W-GAIN_SHIFT){err_q[ERR_W-1]}}, err_q,
						{GAIN_SHIFT{1'b0}}};
					mac_mplier = kp_q;
					state_d    = ST_PROP;
				end
			end
			ST_PROP: begin
				if (!mac_busy) begin
					mac_ctrl.start = 1'b1;
					mac_mcand  = {{(ACC_W-ERR_W-GAIN_SHIFT){nvel_q[ERR_W-1]}}, nvel_q,
						{GAIN_SHIFT{1'b0}}};
					mac_mplier = kd_q;
					state_d    = ST_DERIV;
				end
			end
			ST_DERIV: begin
				if (!mac_busy) begin
					mac_ctrl.start = 1'b1;
					mac_mcand  = {{(ACC_W-INTEG_W){integ_q[INTEG_W-1]}}, integ_q};
					mac_mplier = ki_q;
					state_d    = ST_ITERM;
				end
			end
			ST_ITERM: begin
				if (!mac_busy && out_free) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control state and configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			m_valid_q      <= 1'b0;
			step_time_q    <= STEP_TIME_RESET;
			torque_limit_q <= TORQUE_LIMIT_RESET;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_STEP_TIME: begin
						step_time_q <= cfg_data;
					end
					REG_TORQUE_LIMIT: begin
						torque_limit_q <= cfg_data[LIMIT_W-1:0];
					end
				endcase
			end
		end
	end

	// Captured word, working integral and output payload.
	always_ff @(posedge clk) begin
		if (s_accept) begin
			joint_q <= s_axis_tuser;
			slot_q  <= slot_lut[s_axis_tuser];
			err_q   <= in_err;
			nvel_q  <= in_nvel;
			kp_q    <= s_axis_tdata[3*FIELD_W +: FIELD_W];
			ki_q    <= s_axis_tdata[4*FIELD_W +: FIELD_W];
			kd_q    <= s_axis_tdata[5*FIELD_W +: FIELD_W];
		end
		if (integ_wr) begin
			integ_q <= integ_new;
		end
		if (out_load) begin
			m_torque_q  <= tq_out;
			m_joint_q   <= joint_q;
			m_clamped_q <= tq_clip;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_torque_q;
	assign m_axis_tuser  = {m_clamped_q, m_joint_q};

	mjpt_serial_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (mac_ctrl),
		.mcand  (mac_mcand),
		.mplier (mac_mplier),
		.busy   (mac_busy),
		.acc    (mac_acc)
	);

	mjpt_integ_store #(
		.JOINTS (JOINTS)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (s_accept),
		.rd_addr (slot_lut[s_axis_tuser]),
		.rd_data (old_integ),
		.wr_en   (integ_wr),
		.wr_addr (slot_q),
		.wr_data (integ_new)
	);

endmodule

// File: rtl/core/mjpt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mjpt_checker
// Port-level checks of the torque controller: clamp range, clamp flag,
// output hold under stall and word accounting. Bound to the top level.
// ----------------------------------------------------------------------------
`include "multi_joint_pid_torque_defines.svh"

module mjpt_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_axis_tvalid,
	input logic                              s_axis_tready,
	input logic                              m_axis_tvalid,
	input logic                              m_axis_tready,
	input logic [mjpt_pkg::M_TDATA_W-1:0]    m_axis_tdata,
	input logic [mjpt_pkg::M_TUSER_W-1:0]    m_axis_tuser,
	input logic                              cfg_valid,
	input logic                              cfg_ready,
	input logic [mjpt_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input logic [mjpt_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import mjpt_pkg::*;

	localparam logic [1:0] MAX_WORDS = 2'd2;

	logic [LIMIT_W-1:0]          lim_q;
	logic [1:0]                  words_q;
	logic signed [M_TDATA_W-1:0] lim_pos;
	logic signed [M_TDATA_W-1:0] lim_neg;
	logic signed [M_TDATA_W-1:0] tq;

	assign lim_pos = {1'b0, lim_q};
	assign lim_neg = -lim_pos;
	assign tq      = m_axis_tdata;

	// Mirror of the limit register and count of words in flight.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_q   <= TORQUE_LIMIT_RESET;
			words_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready && (cfg_index == REG_TORQUE_LIMIT)) begin
				lim_q <= cfg_data[LIMIT_W-1:0];
			end
			words_q <= words_q + 2'(s_axis_tvalid && s_axis_tready)
				- 2'(m_axis_tvalid && m_axis_tready);
		end
	end

	`MJPT_ASSERT_SAME(a_torque_in_range, m_axis_tvalid, (tq <= lim_pos) && (tq >= lim_neg), "torque outside the limit")
	`MJPT_ASSERT_SAME(a_clamp_at_limit, m_axis_tvalid && m_axis_tuser[CLAMP_BIT], (tq == lim_pos) || (tq == lim_neg), "clamp flag set away from the limit")
	`MJPT_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")
	`MJPT_ASSERT_SAME(a_no_spurious, m_axis_tvalid && m_axis_tready, words_q != '0, "result without an accepted word")
	`MJPT_ASSERT_SAME(a_bounded, words_q == MAX_WORDS, !s_axis_tready, "word taken with two in flight")

endmodule

bind multi_joint_pid_torque mjpt_checker u_checker (.*);
